// File: rtl/bole_pkg.sv
// Package for the bounded ordered list engine: item types, codes and defaults.
// Used by the channel interfaces, the storage cell and the top level.
`default_nettype none
package bole_pkg;

  localparam int DepthDefault = 64;
  localparam int ValueWidthDefault = 32;

  typedef enum logic [3:0] {
    ActPushFront = 4'd0,
    ActPushBack  = 4'd1,
    ActInsert    = 4'd2,
    ActPopFront  = 4'd3,
    ActPopBack   = 4'd4,
    ActErase     = 4'd5,
    ActRemove    = 4'd6,
    ActClear     = 4'd7,
    ActFind      = 4'd8,
    ActRead      = 4'd9,
    ActReverse   = 4'd10
  } action_t;

  typedef enum logic [2:0] {
    StatOk      = 3'd0,
    StatEmpty   = 3'd1,
    StatRange   = 3'd2,
    StatFull    = 3'd3,
    StatMissing = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmCmp,
    FsmAct,
    FsmRev,
    FsmRes
  } fsm_t;

  // Per-cell move selection
  typedef enum logic [1:0] {
    CellHold,
    CellLoad,
    CellLeft,
    CellRight
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  typedef struct packed {
    logic [3:0]         action;
    logic [6:0]         position;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [5:0]         found_index;
    logic [6:0]         element_count;
    logic               is_empty;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/bole_if.sv
// Valid/ready channel interfaces for action items and result items.
// Depends on bole_pkg for the payload structs.
`default_nettype none
interface bole_in_if;
  logic               valid;
  logic               ready;
  bole_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bole_out_if;
  logic                valid;
  logic                ready;
  bole_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

// File: rtl/bole_cell.sv
// One storage cell of the list: holds a value, loads, or takes a neighbor's value.
// Depends on bole_pkg for the cell control struct.
`default_nettype none
module bole_cell #(
  parameter int ValueWidth = bole_pkg::ValueWidthDefault
) (
  input  wire logic                   clk,
  input  wire bole_pkg::cell_ctrl_t   ctrl,
  input  wire logic [ValueWidth-1:0]  left,
  input  wire logic [ValueWidth-1:0]  right,
  input  wire logic [ValueWidth-1:0]  load,
  output logic      [ValueWidth-1:0]  value
);

  // Move data along the row
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      bole_pkg::CellLoad:  value <= load;
      bole_pkg::CellLeft:  value <= left;
      bole_pkg::CellRight: value <= right;
      default:             value <= value;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: control FSM over a row of cells.
// Depends on bole_pkg, bole_if and bole_cell.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | action, position, item_value
//  rsp     | out | valid/ready | status, read_value, found_index, element_count,
//          |     |             | is_empty, front_value, back_value
//
// Most items go through the states accept, compare, act and result before the next accept.
// Result valid rises once the item has passed the compare and act states.
// Reverse adds a reverse state, one cell-row shift per step, for a list of two or more.
// The row of cells moves all its cells at once on every shift; the FSM handles one item at a time.
// Synchronous reset empties the list; cell contents are not cleared.
// A stalled result holds until rsp.ready; req.ready stays low meanwhile.
`default_nettype none
module bounded_ordered_list_engine #(
  parameter int Depth      = bole_pkg::DepthDefault,
  parameter int ValueWidth = bole_pkg::ValueWidthDefault
) (
  input wire logic    clk,
  input wire logic    rst,
  bole_in_if.sink     req,
  bole_out_if.source  rsp
);

  localparam int CW = $clog2(Depth + 1);
  localparam int IW = $clog2(Depth);
  localparam int XW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {
    ModeHold,
    ModeIns,
    ModeDel,
    ModeRev
  } mode_t;

  bole_pkg::fsm_t           state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            rk, rk_next;
  bole_pkg::action_t        act;
  logic [6:0]               pos;
  logic [ValueWidth-1:0]    val;
  logic [Depth-1:0]         match;
  bole_pkg::status_t        status, status_next;
  logic [ValueWidth-1:0]    rd, rd_next;
  logic [IW-1:0]            fidx, fidx_next;

  logic [ValueWidth-1:0]    vals [Depth];
  bole_pkg::cell_ctrl_t     ctrl [Depth];
  mode_t                    mode;
  logic [CW-1:0]            tgt;
  logic [ValueWidth-1:0]    ld_data;
  logic [ValueWidth-1:0]    back, rd_sel;
  logic [Depth-1:0]         first;
  logic [IW-1:0]            first_idx;
  logic                     any_match;
  logic [XW-1:0]            posx, cntx;
  logic                     full;

  assign posx = XW'(pos);
  assign cntx = XW'(count);
  assign full = (count == CW'(Depth));

  // Select back entry and the entry at the requested position
  always_comb begin
    back   = '0;
    rd_sel = '0;
    for (int i = 0; i < Depth; i++) begin
      if (CW'(i) == CW'(count - CW'(1))) back = back | vals[i];
      if (XW'(i) == posx) rd_sel = rd_sel | vals[i];
    end
  end

  // Isolate the lowest match and encode its index
  assign first     = match & (~match + Depth'(1));
  assign any_match = |match;
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < Depth; i++) begin
      if (first[i]) first_idx = first_idx | IW'(i);
    end
  end

  // Next state and actions
  always_comb begin
    state_next  = state;
    count_next  = count;
    rk_next     = rk;
    status_next = status;
    rd_next     = rd;
    fidx_next   = fidx;
    mode        = ModeHold;
    tgt         = '0;
    unique case (state)
      bole_pkg::FsmIdle: begin
        if (req.valid) state_next = bole_pkg::FsmCmp;
      end
      bole_pkg::FsmCmp: state_next = bole_pkg::FsmAct;
      bole_pkg::FsmAct: begin
        state_next  = bole_pkg::FsmRes;
        status_next = bole_pkg::StatOk;
        rd_next     = '0;
        fidx_next   = '0;
        case (act)
          bole_pkg::ActPushFront, bole_pkg::ActPushBack: begin
            if (full) status_next = bole_pkg::StatFull;
            else begin
              mode       = ModeIns;
              tgt        = (act == bole_pkg::ActPushFront) ? '0 : count;
              count_next = CW'(count + CW'(1));
            end
          end
          bole_pkg::ActInsert: begin
            if (posx > cntx) status_next = bole_pkg::StatRange;
            else if (full) status_next = bole_pkg::StatFull;
            else begin
              mode       = ModeIns;
              tgt        = CW'(pos);
              count_next = CW'(count + CW'(1));
            end
          end
          bole_pkg::ActPopFront, bole_pkg::ActPopBack: begin
            if (count == '0) status_next = bole_pkg::StatEmpty;
            else begin
              mode       = ModeDel;
              tgt        = (act == bole_pkg::ActPopFront) ? '0 : CW'(count - CW'(1));
              count_next = CW'(count - CW'(1));
            end
          end
          bole_pkg::ActErase: begin
            if (count == '0) status_next = bole_pkg::StatEmpty;
            else if (posx >= cntx) status_next = bole_pkg::StatRange;
            else begin
              mode       = ModeDel;
              tgt        = CW'(pos);
              count_next = CW'(count - CW'(1));
            end
          end
          bole_pkg::ActRemove, bole_pkg::ActFind: begin
            if (count == '0) status_next = bole_pkg::StatEmpty;
            else if (!any_match) status_next = bole_pkg::StatMissing;
            else if (act == bole_pkg::ActRemove) begin
              mode       = ModeDel;
              tgt        = CW'(first_idx);
              count_next = CW'(count - CW'(1));
            end else begin
              fidx_next = first_idx;
            end
          end
          bole_pkg::ActClear: count_next = '0;
          bole_pkg::ActRead: begin
            if (count == '0) status_next = bole_pkg::StatEmpty;
            else if (posx >= cntx) status_next = bole_pkg::StatRange;
            else rd_next = rd_sel;
          end
          bole_pkg::ActReverse: begin
            rk_next = '0;
            if (count >= CW'(2)) state_next = bole_pkg::FsmRev;
          end
          default: ;
        endcase
      end
      bole_pkg::FsmRev: begin
        // Move the back entry to slot rk, shifting the rest right
        mode    = ModeRev;
        tgt     = rk;
        rk_next = CW'(rk + CW'(1));
        if (rk == CW'(count - CW'(2))) state_next = bole_pkg::FsmRes;
      end
      bole_pkg::FsmRes: begin
        if (rsp.ready) state_next = bole_pkg::FsmIdle;
      end
      default: state_next = bole_pkg::FsmIdle;
    endcase
  end

  // Per-cell control from mode and target slot
  assign ld_data = (mode == ModeRev) ? back : val;
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      ctrl[i].op = bole_pkg::CellHold;
      unique case (mode)
        ModeIns, ModeRev: begin
          if (CW'(i) == tgt) ctrl[i].op = bole_pkg::CellLoad;
          else if (CW'(i) > tgt) ctrl[i].op = bole_pkg::CellLeft;
        end
        ModeDel: begin
          if (CW'(i) >= tgt) ctrl[i].op = bole_pkg::CellRight;
        end
        default: ;
      endcase
    end
  end

  // Row of cells
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [ValueWidth-1:0] lv, rv;
    if (g == 0) begin : g_first
      assign lv = ld_data;
    end else begin : g_mid
      assign lv = vals[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign rv = vals[g];
    end else begin : g_inner
      assign rv = vals[g+1];
    end
    bole_cell #(.ValueWidth(ValueWidth)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl[g]),
      .left  (lv),
      .right (rv),
      .load  (ld_data),
      .value (vals[g])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bole_pkg::FsmIdle;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Latch the item, compare all cells, hold result fields
  always_ff @(posedge clk) begin
    rk     <= rk_next;
    status <= status_next;
    rd     <= rd_next;
    fidx   <= fidx_next;
    if (state == bole_pkg::FsmIdle && req.valid) begin
      act <= bole_pkg::action_t'(req.item.action);
      pos <= req.item.position;
      val <= ValueWidth'(req.item.item_value);
    end
    if (state == bole_pkg::FsmCmp) begin
      for (int i = 0; i < Depth; i++) begin
        match[i] <= (CW'(i) < count) && (vals[i] == val);
      end
    end
  end

  assign req.ready = (state == bole_pkg::FsmIdle);
  assign rsp.valid = (state == bole_pkg::FsmRes);

  // Drive result fields
  always_comb begin
    rsp.item.status        = status;
    rsp.item.read_value    = 32'(signed'(rd));
    rsp.item.found_index   = 6'(fidx);
    rsp.item.element_count = 7'(count);
    rsp.item.is_empty      = (count == '0);
    rsp.item.front_value   = (count == '0) ? '0 : 32'(signed'(vals[0]));
    rsp.item.back_value    = (count == '0) ? '0 : 32'(signed'(back));
  end

endmodule
`default_nettype wire
